@@ hdl/stnh_pkg.sv @@
package stnh_pkg;

    localparam int COORD_W = 24;
    localparam int D_W     = COORD_W + 1;
    localparam int CR_W    = 2 * D_W + 1;
    localparam int LO_W    = CR_W - D_W;
    localparam int B_W     = LO_W + 1;
    localparam int P_W     = D_W + B_W;
    localparam int ACC_W   = D_W + CR_W + 2;
    localparam int T_FRAC  = 16;
    localparam int T_W     = T_FRAC + 1;
    localparam int CNT_W   = $clog2(T_W);
    localparam int IDX_W   = 3;

    localparam logic [IDX_W-1:0] REG_SX = 3'd0;
    localparam logic [IDX_W-1:0] REG_SY = 3'd1;
    localparam logic [IDX_W-1:0] REG_SZ = 3'd2;
    localparam logic [IDX_W-1:0] REG_EX = 3'd3;
    localparam logic [IDX_W-1:0] REG_EY = 3'd4;
    localparam logic [IDX_W-1:0] REG_EZ = 3'd5;

    localparam logic [T_W-1:0] T_ONE = T_W'(1) << T_FRAC;

    typedef struct packed {
        logic             hit;
        logic             last;
        logic [ACC_W-1:0] num;
        logic [ACC_W-1:0] den;
    } stnh_job_t;

endpackage

@@ hdl/stnh_if.sv @@
interface stnh_tri_if;
    import stnh_pkg::*;
    logic                      valid;
    logic                      ready;
    logic signed [COORD_W-1:0] v0_x;
    logic signed [COORD_W-1:0] v0_y;
    logic signed [COORD_W-1:0] v0_z;
    logic signed [COORD_W-1:0] v1_x;
    logic signed [COORD_W-1:0] v1_y;
    logic signed [COORD_W-1:0] v1_z;
    logic signed [COORD_W-1:0] v2_x;
    logic signed [COORD_W-1:0] v2_y;
    logic signed [COORD_W-1:0] v2_z;
    logic                      last_triangle;
    modport source (output valid, v0_x, v0_y, v0_z, v1_x, v1_y, v1_z,
                    v2_x, v2_y, v2_z, last_triangle, input ready);
    modport sink (input valid, v0_x, v0_y, v0_z, v1_x, v1_y, v1_z,
                  v2_x, v2_y, v2_z, last_triangle, output ready);
endinterface

interface stnh_cfg_if;
    import stnh_pkg::*;
    logic                      valid;
    logic                      ready;
    logic [IDX_W-1:0]          index;
    logic signed [COORD_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

interface stnh_res_if;
    import stnh_pkg::*;
    logic           valid;
    logic           ready;
    logic           any_hit;
    logic [T_W-1:0] nearest_t;
    modport source (output valid, any_hit, nearest_t, input ready);
    modport sink (input valid, any_hit, nearest_t, output ready);
endinterface

@@ hdl/stnh_front.sv @@
module stnh_front
    import stnh_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    stnh_tri_if.sink   tri_in,
    stnh_cfg_if.sink   cfg,
    output logic       job_valid,
    input  logic       job_ready,
    output stnh_job_t  job
);

    localparam logic [1:0] F_IDLE = 2'd0;
    localparam logic [1:0] F_RUN  = 2'd1;
    localparam logic [1:0] F_PUSH = 2'd2;

    localparam logic [2:0] PH_N   = 3'd0;
    localparam logic [2:0] PH_DEN = 3'd1;
    localparam logic [2:0] PH_NUM = 3'd2;
    localparam logic [2:0] PH_E   = 3'd3;
    localparam logic [2:0] PH_V   = 3'd4;
    localparam logic [2:0] PH_W   = 3'd5;
    localparam logic [2:0] SUB_LAST = 3'd5;

    logic [1:0] state_reg, state_next;
    logic [2:0] phase_reg, phase_next;
    logic [2:0] sub_reg, sub_next;

    logic signed [COORD_W-1:0] seg_reg [6];
    logic signed [D_W-1:0] ab_reg [3];
    logic signed [D_W-1:0] ac_reg [3];
    logic signed [D_W-1:0] ap_reg [3];
    logic signed [D_W-1:0] qp_reg [3];
    logic signed [CR_W-1:0] n_reg [3];
    logic signed [CR_W-1:0] e_reg [3];
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [ACC_W-1:0] den_reg, num_reg, v_reg;
    logic                    last_reg;

    function automatic logic signed [D_W-1:0] diff(
        input logic signed [COORD_W-1:0] a,
        input logic signed [COORD_W-1:0] b);
        diff = $signed({a[COORD_W-1], a}) - $signed({b[COORD_W-1], b});
    endfunction

    function automatic logic [1:0] next3(input logic [1:0] k);
        next3 = (k == 2'd2) ? 2'd0 : k + 2'd1;
    endfunction

    logic                    accept;
    logic                    is_cross, odd;
    logic [1:0]              k, a_sel, b_sel;
    logic signed [D_W-1:0]   a_op;
    logic signed [CR_W-1:0]  wide_op;
    logic signed [B_W-1:0]   b_op;
    logic signed [P_W-1:0]   prod;
    logic signed [ACC_W-1:0] prod_ext, addend, acc_in, acc_next;
    logic                    neg;

    assign accept       = tri_in.valid && tri_in.ready;
    assign tri_in.ready = (state_reg == F_IDLE);
    assign cfg.ready    = 1'b1;

    always_comb
    begin
        is_cross = (phase_reg == PH_N) || (phase_reg == PH_E);
        odd      = sub_reg[0];
        k        = sub_reg[2:1];
        a_sel    = odd ? next3(next3(k)) : next3(k);
        b_sel    = odd ? next3(k) : next3(next3(k));
        a_op     = ab_reg[a_sel];
        wide_op  = n_reg[k];
        b_op     = B_W'(ac_reg[b_sel]);
        unique case (phase_reg)
            PH_N:
            begin
                a_op = ab_reg[a_sel];
                b_op = B_W'(ac_reg[b_sel]);
            end
            PH_E:
            begin
                a_op = qp_reg[a_sel];
                b_op = B_W'(ap_reg[b_sel]);
            end
            PH_DEN:
            begin
                a_op    = qp_reg[k];
                wide_op = n_reg[k];
            end
            PH_NUM:
            begin
                a_op    = ap_reg[k];
                wide_op = n_reg[k];
            end
            PH_V:
            begin
                a_op    = ac_reg[k];
                wide_op = e_reg[k];
            end
            default:
            begin
                a_op    = ab_reg[k];
                wide_op = e_reg[k];
            end
        endcase
        if (!is_cross)
        begin
            // split the wide operand: unsigned low part, signed high part
            b_op = odd ? B_W'($signed(wide_op[CR_W-1:LO_W]))
                       : $signed({1'b0, wide_op[LO_W-1:0]});
        end
        prod     = a_op * b_op;
        prod_ext = ACC_W'(prod);
        addend   = (!is_cross && odd) ? (prod_ext <<< LO_W) : prod_ext;
        neg      = (is_cross && odd) || (phase_reg == PH_W);
        // each cross component starts afresh; a dot product only at its first step
        acc_in   = ((sub_reg == 3'd0) || (is_cross && !odd)) ? '0 : acc_reg;
        acc_next = neg ? acc_in - addend : acc_in + addend;
    end

    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        sub_next   = sub_reg;
        unique case (state_reg)
            F_IDLE:
            begin
                if (accept)
                begin
                    state_next = F_RUN;
                    phase_next = PH_N;
                    sub_next   = 3'd0;
                end
            end
            F_RUN:
            begin
                if (sub_reg == SUB_LAST)
                begin
                    sub_next = 3'd0;
                    if (phase_reg == PH_W)
                        state_next = F_PUSH;
                    else
                        phase_next = phase_reg + 3'd1;
                end
                else
                    sub_next = sub_reg + 3'd1;
            end
            F_PUSH:
            begin
                if (job_ready)
                    state_next = F_IDLE;
            end
            default:
                state_next = F_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            phase_reg <= PH_N;
            sub_reg   <= 3'd0;
            for (int i = 0; i < 6; i++)
                seg_reg[i] <= '0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            sub_reg   <= sub_next;
            if (cfg.valid)
            begin
                unique case (cfg.index)
                    REG_SX: seg_reg[0] <= cfg.data;
                    REG_SY: seg_reg[1] <= cfg.data;
                    REG_SZ: seg_reg[2] <= cfg.data;
                    REG_EX: seg_reg[3] <= cfg.data;
                    REG_EY: seg_reg[4] <= cfg.data;
                    REG_EZ: seg_reg[5] <= cfg.data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ab_reg[0] <= diff(tri_in.v1_x, tri_in.v0_x);
            ab_reg[1] <= diff(tri_in.v1_y, tri_in.v0_y);
            ab_reg[2] <= diff(tri_in.v1_z, tri_in.v0_z);
            ac_reg[0] <= diff(tri_in.v2_x, tri_in.v0_x);
            ac_reg[1] <= diff(tri_in.v2_y, tri_in.v0_y);
            ac_reg[2] <= diff(tri_in.v2_z, tri_in.v0_z);
            ap_reg[0] <= diff(seg_reg[0], tri_in.v0_x);
            ap_reg[1] <= diff(seg_reg[1], tri_in.v0_y);
            ap_reg[2] <= diff(seg_reg[2], tri_in.v0_z);
            for (int i = 0; i < 3; i++)
                qp_reg[i] <= diff(seg_reg[i], seg_reg[3 + i]);
            last_reg <= tri_in.last_triangle;
        end
        if (state_reg == F_RUN)
        begin
            acc_reg <= acc_next;
            if (is_cross && odd)
            begin
                if (phase_reg == PH_N)
                    n_reg[k] <= acc_next[CR_W-1:0];
                else
                    e_reg[k] <= acc_next[CR_W-1:0];
            end
            if (sub_reg == SUB_LAST)
            begin
                if (phase_reg == PH_DEN)
                    den_reg <= acc_next;
                if (phase_reg == PH_NUM)
                    num_reg <= acc_next;
                if (phase_reg == PH_V)
                    v_reg <= acc_next;
            end
        end
    end

    // w ends up in the accumulator after the last step
    logic signed [ACC_W:0] vw_sum;
    logic                  hit;

    always_comb
    begin
        vw_sum = {v_reg[ACC_W-1], v_reg} + {acc_reg[ACC_W-1], acc_reg};
        hit = (den_reg > 0) && (num_reg >= 0) && (num_reg <= den_reg)
            && (v_reg >= 0) && (v_reg <= den_reg) && (acc_reg >= 0)
            && (vw_sum <= {den_reg[ACC_W-1], den_reg});
    end

    assign job_valid = (state_reg == F_PUSH);
    assign job.hit   = hit;
    assign job.last  = last_reg;
    assign job.num   = num_reg;
    assign job.den   = den_reg;

endmodule

@@ hdl/stnh_queue.sv @@
module stnh_queue
    import stnh_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  stnh_job_t in_job,
    output logic      out_valid,
    input  logic      out_ready,
    output stnh_job_t out_job
);

    stnh_job_t mem [2];
    logic      wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg;
    logic      push, pop;

    assign in_ready  = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_job   = mem[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            if (push && !pop)
                count_reg <= count_reg + 2'd1;
            else if (pop && !push)
                count_reg <= count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= in_job;
    end

endmodule

@@ hdl/stnh_back.sv @@
module stnh_back
    import stnh_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      job_valid,
    output logic      job_ready,
    input  stnh_job_t job,
    stnh_res_if.source result
);

    logic             busy_reg;
    logic             last_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [ACC_W:0]   rem_reg;
    logic [ACC_W-1:0] den_reg;
    logic [T_W-1:0]   q_reg;
    logic [T_W-1:0]   best_reg;
    logic             seen_reg;
    logic             out_valid_reg;
    logic             any_hit_reg;
    logic [T_W-1:0]   nearest_reg;

    logic             pop, done, take;
    logic [ACC_W:0]   shifted, rem_next;
    logic             qbit;
    logic [T_W-1:0]   q_next, best_new;

    assign take      = out_valid_reg && result.ready;
    assign job_ready = !busy_reg && (!out_valid_reg || result.ready);
    assign pop       = job_valid && job_ready;

    always_comb
    begin
        shifted  = (cnt_reg == '0) ? rem_reg : (rem_reg << 1);
        qbit     = (shifted >= {1'b0, den_reg});
        rem_next = qbit ? shifted - {1'b0, den_reg} : shifted;
        q_next   = {q_reg[T_W-2:0], qbit};
        done     = busy_reg && (cnt_reg == CNT_W'(T_W - 1));
        best_new = (q_next < best_reg) ? q_next : best_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            cnt_reg       <= '0;
            best_reg      <= T_ONE;
            seen_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (take)
                out_valid_reg <= 1'b0;
            if (pop)
            begin
                if (job.hit)
                begin
                    busy_reg <= 1'b1;
                    cnt_reg  <= '0;
                end
                else if (job.last)
                begin
                    out_valid_reg <= 1'b1;
                    best_reg      <= T_ONE;
                    seen_reg      <= 1'b0;
                end
            end
            if (busy_reg)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (done)
                begin
                    busy_reg <= 1'b0;
                    if (last_reg)
                    begin
                        out_valid_reg <= 1'b1;
                        best_reg      <= T_ONE;
                        seen_reg      <= 1'b0;
                    end
                    else
                    begin
                        best_reg <= best_new;
                        seen_reg <= 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            rem_reg  <= {1'b0, job.num};
            den_reg  <= job.den;
            q_reg    <= '0;
            last_reg <= job.last;
            if (!job.hit && job.last)
            begin
                any_hit_reg <= seen_reg;
                nearest_reg <= best_reg;
            end
        end
        if (busy_reg)
        begin
            rem_reg <= rem_next;
            q_reg   <= q_next;
            if (done && last_reg)
            begin
                any_hit_reg <= 1'b1;
                nearest_reg <= best_new;
            end
        end
    end

    assign result.valid     = out_valid_reg;
    assign result.any_hit   = any_hit_reg;
    assign result.nearest_t = nearest_reg;

endmodule

@@ hdl/segment_triangle_nearest_hit_core.sv @@
// Channel   Dir  Beat
// tri_in    in   one triangle: v0..v2 xyz, last_triangle
// cfg       in   register index, segment coordinate
// result    out  any_hit, nearest_t (only after a last triangle)
//
// A triangle is taken while the front is idle, runs 36 multiply steps
// through the single shared 25 x 27 multiplier and is handed on when the
// queue has room. The back divides hits, overlapped with the next triangle.
// A two-entry queue lets the front keep going while a result waits.
// Reset clears the segment registers, the running nearest hit and all
// control state; no clearing pass.
module segment_triangle_nearest_hit_core
    import stnh_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    stnh_tri_if.sink    tri_in,
    stnh_cfg_if.sink    cfg,
    stnh_res_if.source  result
);

    logic      fj_valid, fj_ready, bj_valid, bj_ready;
    stnh_job_t fj, bj;

    stnh_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .tri_in    (tri_in),
        .cfg       (cfg),
        .job_valid (fj_valid),
        .job_ready (fj_ready),
        .job       (fj)
    );

    stnh_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fj_valid),
        .in_ready  (fj_ready),
        .in_job    (fj),
        .out_valid (bj_valid),
        .out_ready (bj_ready),
        .out_job   (bj)
    );

    stnh_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (bj_valid),
        .job_ready (bj_ready),
        .job       (bj),
        .result    (result)
    );

endmodule

@@ tb/stnh_checker.sv @@
module stnh_checker
    import stnh_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    stnh_tri_if   tri_w,
    stnh_cfg_if   cfg_w,
    stnh_res_if   res_w,
    output int    fail_count,
    output int    pending
);

    typedef logic signed [127:0] wide_t;

    typedef struct {
        logic           any_hit;
        logic [T_W-1:0] nearest_t;
    } query_result_t;

    logic signed [COORD_W-1:0] seg_coord [6];
    logic [T_W-1:0]            best_t;
    logic                      hit_seen;
    query_result_t             answers [$];

    function automatic wide_t dot3(wide_t a0, wide_t a1, wide_t a2,
                                   wide_t b0, wide_t b1, wide_t b2);
        return a0 * b0 + a1 * b1 + a2 * b2;
    endfunction

    // Returns 1 and the Q1.16 parameter when the triangle is hit from the front
    function automatic logic segment_hits(input logic signed [COORD_W-1:0] vtx [9],
                                          output logic [T_W-1:0] t_out);
        wide_t s [3];
        wide_t ab [3];
        wide_t ac [3];
        wide_t qp [3];
        wide_t ap [3];
        wide_t nrm [3];
        wide_t ecr [3];
        wide_t den, num, vb, wb, quo;
        t_out = '0;
        for (int i = 0; i < 3; i++)
        begin
            s[i]  = wide_t'(seg_coord[i]);
            qp[i] = s[i] - wide_t'(seg_coord[3 + i]);
            ab[i] = wide_t'(vtx[3 + i]) - wide_t'(vtx[i]);
            ac[i] = wide_t'(vtx[6 + i]) - wide_t'(vtx[i]);
            ap[i] = s[i] - wide_t'(vtx[i]);
        end
        nrm[0] = ab[1] * ac[2] - ab[2] * ac[1];
        nrm[1] = ab[2] * ac[0] - ab[0] * ac[2];
        nrm[2] = ab[0] * ac[1] - ab[1] * ac[0];
        den = dot3(qp[0], qp[1], qp[2], nrm[0], nrm[1], nrm[2]);
        if (den <= 0)
            return 1'b0;
        num = dot3(ap[0], ap[1], ap[2], nrm[0], nrm[1], nrm[2]);
        if (num < 0 || num > den)
            return 1'b0;
        ecr[0] = qp[1] * ap[2] - qp[2] * ap[1];
        ecr[1] = qp[2] * ap[0] - qp[0] * ap[2];
        ecr[2] = qp[0] * ap[1] - qp[1] * ap[0];
        vb = dot3(ac[0], ac[1], ac[2], ecr[0], ecr[1], ecr[2]);
        if (vb < 0 || vb > den)
            return 1'b0;
        wb = -dot3(ab[0], ab[1], ab[2], ecr[0], ecr[1], ecr[2]);
        if (wb < 0 || vb + wb > den)
            return 1'b0;
        quo = (num <<< T_FRAC) / den;
        t_out = quo[T_W-1:0];
        return 1'b1;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        logic signed [COORD_W-1:0] vtx [9];
        logic [T_W-1:0]            t_hit;
        query_result_t             exp_res;
        if (!rst_n)
        begin
            for (int i = 0; i < 6; i++)
                seg_coord[i] <= '0;
            best_t     <= T_ONE;
            hit_seen   <= 1'b0;
            fail_count <= 0;
            answers.delete();
            pending    <= 0;
        end
        else
        begin
            if (cfg_w.valid && cfg_w.ready && cfg_w.index <= REG_EZ)
                seg_coord[cfg_w.index] <= cfg_w.data;
            if (tri_w.valid && tri_w.ready)
            begin
                vtx = '{tri_w.v0_x, tri_w.v0_y, tri_w.v0_z,
                        tri_w.v1_x, tri_w.v1_y, tri_w.v1_z,
                        tri_w.v2_x, tri_w.v2_y, tri_w.v2_z};
                exp_res.any_hit   = hit_seen;
                exp_res.nearest_t = best_t;
                if (segment_hits(vtx, t_hit))
                begin
                    exp_res.any_hit = 1'b1;
                    if (t_hit < best_t)
                        exp_res.nearest_t = t_hit;
                end
                if (tri_w.last_triangle)
                begin
                    answers.push_back(exp_res);
                    best_t   <= T_ONE;
                    hit_seen <= 1'b0;
                end
                else
                begin
                    best_t   <= exp_res.nearest_t;
                    hit_seen <= exp_res.any_hit;
                end
            end
            if (res_w.valid && res_w.ready)
            begin
                if (answers.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("result beat with nothing expected: hit %0b t %0d",
                                 res_w.any_hit, res_w.nearest_t);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    exp_res = answers.pop_front();
                    if (res_w.any_hit !== exp_res.any_hit
                        || res_w.nearest_t !== exp_res.nearest_t)
                    begin
                        if (fail_count < 10)
                            $display("mismatch: expected hit %0b t %0d, got hit %0b t %0d",
                                     exp_res.any_hit, exp_res.nearest_t,
                                     res_w.any_hit, res_w.nearest_t);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            pending <= answers.size();
        end
    end

endmodule

@@ tb/tb.sv @@
module tb;
    import stnh_pkg::*;

    localparam int CYCLE_LIMIT = 600000;
    localparam int SETTLE      = 80;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic calm = 1'b0;
    logic tri_taken = 1'b0;
    logic cfg_taken = 1'b0;
    int   fail_count;
    int   pending;
    int   cycles = 0;
    int   res_hold = 0;

    stnh_tri_if tri_w ();
    stnh_cfg_if cfg_w ();
    stnh_res_if res_w ();

    segment_triangle_nearest_hit_core u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .tri_in (tri_w),
        .cfg    (cfg_w),
        .result (res_w)
    );

    stnh_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .tri_w      (tri_w),
        .cfg_w      (cfg_w),
        .res_w      (res_w),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        tri_taken <= tri_w.valid && tri_w.ready;
        cfg_taken <= cfg_w.valid && cfg_w.ready;
        cycles    <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb failed");
            $finish;
        end
    end

    // Result back-pressure in bursts
    always @(negedge clk)
    begin
        int hold;
        hold = res_hold;
        if (!calm && hold == 0 && $urandom_range(0, 7) == 0)
            hold = $urandom_range(1, 15);
        res_w.ready <= (hold == 0);
        res_hold    <= (hold > 0) ? hold - 1 : 0;
    end

    initial
    begin
        tri_w.valid = 1'b0;
        {tri_w.v0_x, tri_w.v0_y, tri_w.v0_z, tri_w.v1_x, tri_w.v1_y, tri_w.v1_z,
         tri_w.v2_x, tri_w.v2_y, tri_w.v2_z, tri_w.last_triangle} = '0;
        cfg_w.valid = 1'b0;
        cfg_w.index = REG_SX;
        cfg_w.data  = '0;
        res_w.ready = 1'b1;
    end

    task automatic write_reg(input logic [IDX_W-1:0] idx, input longint value);
        @(negedge clk);
        cfg_w.valid <= 1'b1;
        cfg_w.index <= idx;
        cfg_w.data  <= value[COORD_W-1:0];
        do @(negedge clk); while (!cfg_taken);
        cfg_w.valid <= 1'b0;
    endtask

    // Wait for the block to drain before touching the segment
    task automatic settle();
        while (pending != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic set_segment(input longint s[3], input longint e[3]);
        settle();
        write_reg(REG_SX, s[0]);
        write_reg(REG_SY, s[1]);
        write_reg(REG_SZ, s[2]);
        write_reg(REG_EX, e[0]);
        write_reg(REG_EY, e[1]);
        write_reg(REG_EZ, e[2]);
        // indexes past the last register must be dropped
        if ($urandom_range(0, 1))
            write_reg(IDX_W'($urandom_range(6, 7)), longint'($urandom));
    endtask

    task automatic send_tri(input longint c[9], input logic last);
        if (!calm && $urandom_range(0, 4) == 0)
            repeat ($urandom_range(1, 15)) @(negedge clk);
        else
            @(negedge clk);
        tri_w.valid <= 1'b1;
        tri_w.v0_x <= c[0][COORD_W-1:0];
        tri_w.v0_y <= c[1][COORD_W-1:0];
        tri_w.v0_z <= c[2][COORD_W-1:0];
        tri_w.v1_x <= c[3][COORD_W-1:0];
        tri_w.v1_y <= c[4][COORD_W-1:0];
        tri_w.v1_z <= c[5][COORD_W-1:0];
        tri_w.v2_x <= c[6][COORD_W-1:0];
        tri_w.v2_y <= c[7][COORD_W-1:0];
        tri_w.v2_z <= c[8][COORD_W-1:0];
        tri_w.last_triangle <= last;
        do @(negedge clk); while (!tri_taken);
        tri_w.valid <= 1'b0;
    endtask

    // Flat triangle at height z around the z axis; flip reverses the winding
    task automatic flat_tri(input longint z, input bit flip, input longint sz,
                            input logic last);
        longint c[9];
        if (flip)
            c = '{-sz, -sz, z, 0, sz, z, sz, -sz, z};
        else
            c = '{-sz, -sz, z, sz, -sz, z, 0, sz, z};
        send_tri(c, last);
    endtask

    task automatic random_phase(input int count, input bit full_range);
        longint s[3], e[3], c[9], p[3];
        longint span, spread, f;
        span = full_range ? 64'd8388607 : (64'd1 << $urandom_range(6, 21));
        for (int i = 0; i < 3; i++)
        begin
            s[i] = $signed($urandom_range(0, 2 * span)) - span;
            e[i] = $signed($urandom_range(0, 2 * span)) - span;
        end
        set_segment(s, e);
        for (int n = 0; n < count; n++)
        begin
            if (full_range || $urandom_range(0, 9) == 0)
            begin
                for (int i = 0; i < 9; i++)
                    c[i] = longint'($signed($urandom));
            end
            else
            begin
                f = $urandom_range(0, 256);
                spread = (span >> $urandom_range(0, 3)) + 1;
                if (spread > 2097151)
                    spread = 2097151;
                for (int i = 0; i < 3; i++)
                    p[i] = s[i] + ((e[i] - s[i]) * f) / 256;
                for (int i = 0; i < 9; i++)
                    c[i] = p[i % 3] + $signed($urandom_range(0, 2 * spread)) - spread;
            end
            send_tri(c, n == count - 1 || $urandom_range(0, 3) == 0);
        end
    endtask

    initial
    begin
        longint s[3], e[3], c[9];
        repeat (4) @(negedge clk);
        rst_n = 1'b1;

        s = '{0, 0, 1000};
        e = '{0, 0, -1000};
        set_segment(s, e);
        flat_tri(0, 0, 1000, 1'b1);        // plain hit at half way
        flat_tri(0, 1, 1000, 1'b1);        // facing away
        flat_tri(-1000, 0, 1000, 1'b1);    // hit at the segment end
        flat_tri(1000, 0, 1000, 1'b1);     // hit at the segment start
        flat_tri(2000, 0, 1000, 1'b0);     // beyond the segment
        flat_tri(500, 0, 1000, 1'b0);
        flat_tri(500, 0, 1000, 1'b0);      // equal t again
        flat_tri(-500, 0, 1000, 1'b1);     // farther hit keeps the nearer one
        c = '{1, 1, 0, 2, 2, 0, 3, 3, 0};  // zero area
        send_tri(c, 1'b0);
        c = '{5000, 5000, 0, 7000, 5000, 0, 6000, 7000, 0};  // off to the side
        send_tri(c, 1'b1);
        c = '{0, 0, 0, 0, 0, 0, 0, 0, 0};
        send_tri(c, 1'b1);
        c = '{-1000, 0, 0, 1000, 0, 0, 0, 1000, 0};  // segment through an edge
        send_tri(c, 1'b1);
        c = '{8388607, 8388607, 8388607, -8388608, -8388608, -8388608,
              8388607, -8388608, 8388607};
        send_tri(c, 1'b0);
        c = '{-8388608, 8388607, -8388608, 8388607, -8388608, 8388607,
              -8388608, -8388608, 8388607};
        send_tri(c, 1'b1);

        s = '{8388607, -8388608, 8388607};
        e = '{-8388608, 8388607, -8388608};
        set_segment(s, e);
        c = '{-8388608, -8388608, 0, 8388607, -8388608, 0, 0, 8388607, 0};
        send_tri(c, 1'b0);
        c = '{-8388608, -8388608, 0, 0, 8388607, 0, 8388607, -8388608, 0};
        send_tri(c, 1'b1);

        for (int ph = 0; ph < 8; ph++)
            random_phase(110, ph == 3);
        calm = 1'b1;
        random_phase(100, 1'b0);

        settle();
        if (fail_count == 0 && pending == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule

@@ sim.f @@
hdl/stnh_pkg.sv
hdl/stnh_if.sv
hdl/stnh_front.sv
hdl/stnh_queue.sv
hdl/stnh_back.sv
hdl/segment_triangle_nearest_hit_core.sv
tb/stnh_checker.sv
tb/tb.sv
